### design/rise_pkg.sv
// Package for the RV64I/C instruction sequence encoder.
// Payload structs, opcodes, mode codes and shared encode functions; no dependencies.
package rise_pkg;

	localparam int unsigned MaxSeq = 6;

	typedef enum logic [4:0] {
		MODE_ADDI = 5'd0, MODE_ADDIW = 5'd1, MODE_SLLI = 5'd2, MODE_LI = 5'd3,
		MODE_ADDSP = 5'd4, MODE_SDSP = 5'd5, MODE_LDSP = 5'd6, MODE_JALR = 5'd7,
		MODE_LUI = 5'd8, MODE_AUIPC = 5'd9, MODE_JAL = 5'd10, MODE_SD = 5'd11,
		MODE_LD = 5'd12, MODE_NOP = 5'd13, MODE_STORESYM = 5'd14,
		MODE_LOADSYM = 5'd15, MODE_JUMP2GB = 5'd16
	} mode_t;

	localparam logic [6:0] OpLui   = 7'h37;
	localparam logic [6:0] OpAuipc = 7'h17;
	localparam logic [6:0] OpImm   = 7'h13;
	localparam logic [6:0] OpImmW  = 7'h1B;
	localparam logic [6:0] OpStore = 7'h23;
	localparam logic [6:0] OpLoad  = 7'h03;
	localparam logic [6:0] OpJal   = 7'h6f;
	localparam logic [6:0] OpJalr  = 7'h67;
	localparam logic [4:0] RegSp   = 5'd2;
	localparam logic [4:0] RegRa   = 5'd1;

	localparam logic [1:0] AddrCfgEnable = 2'd0;

	typedef struct packed {
		logic [4:0]         mode;
		logic [4:0]         dest_reg;
		logic [4:0]         src_reg;
		logic [4:0]         temp_reg;
		logic signed [31:0] immediate;
		logic [63:0]        from_addr;
		logic [63:0]        to_addr;
		logic               absolute_jump;
	} req_t;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [2:0]  length;
		logic        last;
	} rsp_t;

	// one encoded instruction: length 0 means failed
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  len;
	} ins_t;

	// decoded, pre-split operands passed from stage 1 to stage 2
	typedef struct packed {
		logic        abs_j;
		logic        fail;
		logic [4:0]  mode;
		logic [4:0]  rd;
		logic [4:0]  rs;
		logic [4:0]  tr;
		logic [31:0] imm;
		logic [19:0] hi;     // auipc hi / lui hi of abs jump
		logic [11:0] lo;     // auipc lo / mid of abs jump
		logic        mid_nz;
		logic [15:0] low16;  // abs jump low 16 bits
	} dec_t;

	function automatic ins_t ins_fail();
		ins_t r;
		r.word = '0;
		r.len  = 3'd0;
		return r;
	endfunction

	function automatic ins_t ins_full(input logic [31:0] w);
		ins_t r;
		r.word = w;
		r.len  = 3'd4;
		return r;
	endfunction

	function automatic ins_t ins_c(input logic [15:0] w);
		ins_t r;
		r.word = {16'h0, w};
		r.len  = 3'd2;
		return r;
	endfunction

	function automatic logic fits12(input logic [31:0] v);
		return (v[31:11] == '0) || (v[31:11] == '1);
	endfunction

	function automatic logic fits6(input logic [31:0] v);
		return (v[31:5] == '0) || (v[31:5] == '1);
	endfunction

	function automatic ins_t enc_imm(input logic [4:0] rd, input logic [4:0] rs,
			input logic [31:0] imm, input logic [6:0] op);
		if (rd == 5'd0 || !fits12(imm))
			return ins_fail();
		return ins_full({imm[11:0], rs, 3'd0, rd, op});
	endfunction

	function automatic ins_t enc_upper(input logic [4:0] rd, input logic [31:0] imm,
			input logic [6:0] op);
		if (rd == 5'd0 || !((imm[31:19] == '0) || (imm[31:19] == '1)))
			return ins_fail();
		return ins_full({imm[19:0], rd, op});
	endfunction

	function automatic ins_t enc_sd(input logic [4:0] data, input logic [4:0] base,
			input logic [31:0] imm);
		if (!fits12(imm))
			return ins_fail();
		return ins_full({imm[11:5], data, base, 3'd3, imm[4:0], OpStore});
	endfunction

	function automatic ins_t enc_ld(input logic [4:0] rd, input logic [4:0] base,
			input logic [31:0] imm);
		if (!fits12(imm))
			return ins_fail();
		return ins_full({imm[11:0], base, 3'd3, rd, OpLoad});
	endfunction

	function automatic ins_t enc_addi(input logic ce, input logic [4:0] rd,
			input logic [4:0] rs, input logic [31:0] imm);
		if (ce && rd == rs && rd != 5'd0 && imm != '0 && fits6(imm))
			return ins_c({3'b000, imm[5], rd, imm[4:0], 2'b01});
		return enc_imm(rd, rs, imm, OpImm);
	endfunction

	function automatic ins_t enc_addiw(input logic ce, input logic [4:0] rd,
			input logic [4:0] rs, input logic [31:0] imm);
		if (ce && rd == rs && rd != 5'd0 && fits6(imm))
			return ins_c({3'b001, imm[5], rd, imm[4:0], 2'b01});
		return enc_imm(rd, rs, imm, OpImmW);
	endfunction

	function automatic ins_t enc_slli(input logic ce, input logic [4:0] rd,
			input logic [4:0] rs, input logic [31:0] imm);
		logic in_rng;
		in_rng = (imm[31:6] == '0);
		if (ce && rd == rs && rd != 5'd0 && in_rng && imm[5:0] != 6'd0)
			return ins_c({3'b000, imm[5], rd, imm[4:0], 2'b10});
		if (rd == 5'd0 || !in_rng)
			return ins_fail();
		return ins_full({6'd0, imm[5:0], rs, 3'd1, rd, OpImm});
	endfunction

	function automatic ins_t enc_jalr(input logic ce, input logic [4:0] rd,
			input logic [4:0] rs, input logic [31:0] imm);
		if (ce && imm == '0 && rs != 5'd0 && (rd == 5'd0 || rd == RegRa))
			return ins_c({(rd == 5'd0) ? 4'h8 : 4'h9, rs, 5'd0, 2'b10});
		if (!fits12(imm))
			return ins_fail();
		return ins_full({imm[11:0], rs, 3'd0, rd, OpJalr});
	endfunction

endpackage

### design/rise_decode.sv
// Stage 1: operand decode, pc-relative split and absolute-address split.
// Depends on rise_pkg.
module rise_decode (
	input  rise_pkg::req_t req,
	output rise_pkg::dec_t dec
);
	logic [63:0] delta;
	logic [63:0] dsum;
	logic [63:0] hsum;
	logic [11:0] mid;
	logic        pcrel;

	always_comb begin
		delta = req.to_addr - req.from_addr;
		dsum  = delta + 64'h8000_0800;
		hsum  = delta + 64'h800;
		mid   = req.to_addr[27:16];
		// only the symbol and 2 GB jump patterns depend on the pc delta
		pcrel = (req.mode == rise_pkg::MODE_STORESYM) || (req.mode == rise_pkg::MODE_LOADSYM) ||
			(req.mode == rise_pkg::MODE_JUMP2GB);
		dec.abs_j  = req.absolute_jump;
		dec.mode   = req.mode;
		dec.rd     = req.dest_reg;
		dec.rs     = req.src_reg;
		dec.tr     = req.temp_reg;
		dec.imm    = req.immediate;
		dec.low16  = req.to_addr[15:0];
		dec.mid_nz = (mid != 12'd0);
		if (req.absolute_jump) begin
			dec.fail = (req.to_addr[63:48] != 16'd0);
			dec.hi   = req.to_addr[47:28] + {19'd0, mid[11]};
			dec.lo   = mid;
		end else begin
			dec.fail = pcrel && ((delta == 64'd0) || (dsum[63:32] != 32'd0));
			dec.hi   = hsum[31:12];
			dec.lo   = delta[11:0];
		end
	end
endmodule

### design/rise_encode.sv
// Stage 2: builds up to six instruction words and the count for one request.
// Depends on rise_pkg.
module rise_encode (
	input  logic                                     ce,
	input  rise_pkg::dec_t                           dec,
	output rise_pkg::ins_t [rise_pkg::MaxSeq-1:0]    ins,
	output logic [2:0]                               cnt
);
	logic [31:0] imm;
	logic [31:0] hi_s;
	logic [31:0] lo_s;
	logic [3:0]  up4;
	logic [11:0] lo12;
	logic [4:0]  up4_adj;
	logic        lo12_neg;
	logic        bad;
	logic [2:0]  n;

	always_comb begin
		imm  = dec.imm;
		hi_s = {{12{dec.hi[19]}}, dec.hi};
		lo_s = {{20{dec.lo[11]}}, dec.lo};
		up4  = dec.low16[15:12];
		lo12 = dec.low16[11:0];
		lo12_neg = lo12[11];
		up4_adj = {1'b0, up4} + {4'd0, lo12_neg};
		for (int i = 0; i < rise_pkg::MaxSeq; i++)
			ins[i] = rise_pkg::ins_fail();
		n = 3'd1;
		bad = dec.fail;
		if (dec.abs_j) begin
			// abs hi is to[47:28] (+1), must fit 20 signed; lui of rs
			ins[0] = rise_pkg::enc_upper(dec.rs, {12'd0, dec.hi}, rise_pkg::OpLui);
			if (dec.hi == 20'd0 && dec.lo[11])
				ins[0] = rise_pkg::enc_upper(dec.rs, 32'h0010_0000, rise_pkg::OpLui);
			n = 3'd1;
			if (dec.mid_nz) begin
				ins[n] = rise_pkg::enc_addiw(ce, dec.rs, dec.rs, lo_s);
				n = n + 3'd1;
			end
			if (dec.low16 == 16'd0) begin
				ins[n]         = rise_pkg::enc_slli(ce, dec.rs, dec.rs, 32'd16);
				ins[n + 3'd1]  = rise_pkg::enc_jalr(ce, dec.rd, dec.rs, 32'd0);
				n = n + 3'd2;
			end else begin
				ins[n] = rise_pkg::enc_slli(ce, dec.rs, dec.rs, 32'd4);
				n = n + 3'd1;
				if (up4_adj != 5'd0) begin
					ins[n] = rise_pkg::enc_addi(ce, dec.rs, dec.rs, {27'd0, up4_adj});
					n = n + 3'd1;
				end
				ins[n]        = rise_pkg::enc_slli(ce, dec.rs, dec.rs, 32'd12);
				ins[n + 3'd1] = rise_pkg::enc_jalr(ce, dec.rd, dec.rs,
					{{20{lo12[11]}}, lo12});
				n = n + 3'd2;
			end
		end else begin
			unique case (dec.mode)
				rise_pkg::MODE_ADDI:  ins[0] = rise_pkg::enc_addi(ce, dec.rd, dec.rs, imm);
				rise_pkg::MODE_ADDIW: ins[0] = rise_pkg::enc_addiw(ce, dec.rd, dec.rs, imm);
				rise_pkg::MODE_SLLI:  ins[0] = rise_pkg::enc_slli(ce, dec.rd, dec.rs, imm);
				rise_pkg::MODE_LI: begin
					if (ce && rise_pkg::fits6(imm))
						ins[0] = rise_pkg::ins_c({3'b010, imm[5], dec.rd, imm[4:0], 2'b01});
					else
						ins[0] = rise_pkg::enc_imm(dec.rd, 5'd0, imm, rise_pkg::OpImm);
				end
				rise_pkg::MODE_ADDSP: begin
					if (ce && imm != '0 && imm[3:0] == 4'd0 &&
							((imm[31:9] == '0) || (imm[31:9] == '1)))
						ins[0] = rise_pkg::ins_c({3'b011, imm[9], rise_pkg::RegSp, imm[4],
							imm[6], imm[8:7], imm[5], 2'b01});
					else
						ins[0] = rise_pkg::enc_imm(rise_pkg::RegSp, rise_pkg::RegSp, imm,
							rise_pkg::OpImm);
				end
				rise_pkg::MODE_SDSP: begin
					if (ce && imm[31:9] == '0 && imm[2:0] == 3'd0)
						ins[0] = rise_pkg::ins_c({3'b111, imm[5:3], imm[8:6], dec.rs, 2'b10});
					else
						ins[0] = rise_pkg::enc_sd(dec.rs, rise_pkg::RegSp, imm);
				end
				rise_pkg::MODE_LDSP: begin
					if (ce && dec.rd != 5'd0 && imm[31:9] == '0 && imm[2:0] == 3'd0)
						ins[0] = rise_pkg::ins_c({3'b011, imm[5], dec.rd, imm[4:3],
							imm[8:6], 2'b10});
					else
						ins[0] = rise_pkg::enc_ld(dec.rd, rise_pkg::RegSp, imm);
				end
				rise_pkg::MODE_JALR:  ins[0] = rise_pkg::enc_jalr(ce, dec.rd, dec.rs, imm);
				rise_pkg::MODE_LUI:   ins[0] = rise_pkg::enc_upper(dec.rd, imm, rise_pkg::OpLui);
				rise_pkg::MODE_AUIPC:
					ins[0] = rise_pkg::enc_upper(dec.rd, imm, rise_pkg::OpAuipc);
				rise_pkg::MODE_JAL: begin
					if ((imm[31:20] == '0) || (imm[31:20] == '1))
						ins[0] = rise_pkg::ins_full({imm[20], imm[10:1], imm[11], imm[19:12],
							dec.rd, rise_pkg::OpJal});
				end
				rise_pkg::MODE_SD:    ins[0] = rise_pkg::enc_sd(dec.rs, dec.tr, imm);
				rise_pkg::MODE_LD:    ins[0] = rise_pkg::enc_ld(dec.rd, dec.rs, imm);
				rise_pkg::MODE_NOP:
					ins[0] = ce ? rise_pkg::ins_c(16'h0001) : rise_pkg::ins_full(32'h13);
				rise_pkg::MODE_STORESYM: begin
					ins[0] = rise_pkg::enc_upper(dec.tr, hi_s, rise_pkg::OpAuipc);
					ins[1] = rise_pkg::enc_sd(dec.rs, dec.tr, lo_s);
					n = 3'd2;
				end
				rise_pkg::MODE_LOADSYM: begin
					ins[0] = rise_pkg::enc_upper(dec.rd, hi_s, rise_pkg::OpAuipc);
					ins[1] = rise_pkg::enc_ld(dec.rd, dec.rd, lo_s);
					n = 3'd2;
				end
				rise_pkg::MODE_JUMP2GB: begin
					ins[0] = rise_pkg::enc_upper(dec.rs, hi_s, rise_pkg::OpAuipc);
					ins[1] = rise_pkg::enc_jalr(ce, dec.rd, dec.rs, lo_s);
					n = 3'd2;
				end
				default: bad = 1'b1;
			endcase
		end
		for (int i = 0; i < rise_pkg::MaxSeq; i++)
			if (i < n && ins[i].len == 3'd0)
				bad = 1'b1;
		if (bad) begin
			for (int i = 0; i < rise_pkg::MaxSeq; i++)
				ins[i] = rise_pkg::ins_fail();
			cnt = 3'd1;
		end else begin
			cnt = n;
		end
	end
endmodule

### design/rise_serializer.sv
// Output stage: walks the encoded list one beat per cycle while out_ready is high, skid-free register.
// Depends on rise_pkg.
module rise_serializer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  rise_pkg::ins_t [rise_pkg::MaxSeq-1:0] in_ins,
	input  logic [2:0]                            in_cnt,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output rise_pkg::rsp_t                        out_rsp
);
	rise_pkg::ins_t [rise_pkg::MaxSeq-1:0] ins_q;
	logic [2:0] cnt_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       fin;

	assign fin       = busy_q && out_ready && (idx_q + 3'd1 == cnt_q);
	assign in_ready  = !busy_q || fin;
	assign out_valid = busy_q;

	always_comb begin
		out_rsp.instr_word = ins_q[idx_q].word;
		out_rsp.length     = ins_q[idx_q].len;
		out_rsp.last       = (idx_q + 3'd1 == cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (busy_q && out_ready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ins_q <= in_ins;
			cnt_q <= in_cnt;
		end
	end

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < cnt_q) else $error("index past count");
	a_cnt_nz: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != 3'd0 && cnt_q <= 3'd6)) else $error("bad count");
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_rsp.length == 3'd0) |-> out_rsp.last) else $error("fail not last");
`endif
endmodule

### design/riscv_instruction_sequence_encoder_unit.sv
// Top level of the RV64I/C instruction sequence encoder.
// Depends on rise_pkg, rise_decode, rise_encode, rise_serializer.
//
// channel  | handshake           | payload
// ---------+---------------------+-----------------------------
// request  | req_valid/req_ready | req  (rise_pkg::req_t)
// result   | rsp_valid/rsp_ready | rsp  (rise_pkg::rsp_t)
// config   | APB psel/penable    | paddr/pwdata/prdata
//
// A request is registered after decode (s1), after encode (s2) and in the
// output register. A request of n instructions holds the output register
// for n beats; the next request enters it as the last beat is taken, so the
// single output port sets the sustained rate. Stalls back up through valid
// bits in each stage; nothing is dropped or repeated. Reset clears valids and
// sets compressed_enable to 1.
module riscv_instruction_sequence_encoder_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  rise_pkg::req_t       req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rise_pkg::rsp_t       rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [1:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	logic compressed_enable_q;

	// stage 1: decoded request
	rise_pkg::dec_t dec_c, dec_s1;
	logic v_s1;
	// stage 2: encoded list
	rise_pkg::ins_t [rise_pkg::MaxSeq-1:0] ins_c, ins_s2;
	logic [2:0] cnt_c, cnt_s2;
	logic v_s2;
	logic ser_ready, rdy_s2, rdy_s1;

	assign pready = 1'b1;
	assign prdata = (paddr == rise_pkg::AddrCfgEnable) ? {31'd0, compressed_enable_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			compressed_enable_q <= 1'b1;
		else if (psel && penable && pwrite && paddr == rise_pkg::AddrCfgEnable)
			compressed_enable_q <= pwdata[0];
	end

	rise_decode u_dec (.req(req), .dec(dec_c));

	assign rdy_s2    = !v_s2 || ser_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) dec_s1 <= dec_c;
		if (rdy_s2 && v_s1) begin
			ins_s2 <= ins_c;
			cnt_s2 <= cnt_c;
		end
	end

	rise_encode u_enc (.ce(compressed_enable_q), .dec(dec_s1), .ins(ins_c), .cnt(cnt_c));

	rise_serializer u_ser (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s2), .in_ready(ser_ready), .in_ins(ins_s2), .in_cnt(cnt_s2),
		.out_valid(rsp_valid), .out_ready(rsp_ready), .out_rsp(rsp)
	);

`ifndef ASSERT_OFF
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ser_ready) |=> v_s2) else $error("s2 item lost");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy_s2) |=> v_s1) else $error("s1 item lost");
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (!v_s1 || !v_s2 || ser_ready)) else $error("ready chain broken");
`endif
endmodule

### tb/sv/rise_encode_checker.sv
// Result checker for the instruction sequence encoder: watches both beat channels and the
// config port, predicts each request's instruction words and compares them in order.
// Depends on rise_pkg for the payload structs, opcodes and mode codes.
module rise_encode_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  rise_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  rise_pkg::rsp_t rsp,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [1:0]     paddr,
	input  logic [31:0]    pwdata,
	input  logic           pready,
	output int             errors,
	output int             pending,
	output int             beats_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import rise_pkg::*;

	typedef struct packed {
		logic [31:0] w;
		logic [2:0]  n;
	} code_t;

	logic  ce;
	rsp_t  expected_beats[$];

	function automatic code_t c_full(input logic [31:0] w);
		return {w, 3'd4};
	endfunction

	function automatic code_t c_short(input logic [15:0] w);
		return {16'h0, w, 3'd2};
	endfunction

	function automatic bit in12(input longint v);
		return v >= -2048 && v <= 2047;
	endfunction

	function automatic code_t c_itype(input logic [4:0] rd, input logic [4:0] rs,
			input longint imm, input logic [6:0] op);
		if (rd == 0 || !in12(imm))
			return '0;
		return c_full({imm[11:0], rs, 3'b000, rd, op});
	endfunction

	function automatic code_t c_upper(input logic [4:0] rd, input longint imm,
			input logic [6:0] op);
		if (rd == 0 || imm < -524288 || imm > 524287)
			return '0;
		return c_full({imm[19:0], rd, op});
	endfunction

	function automatic code_t c_store(input logic [4:0] data, input logic [4:0] base,
			input longint imm);
		if (!in12(imm))
			return '0;
		return c_full({imm[11:5], data, base, 3'd3, imm[4:0], OpStore});
	endfunction

	function automatic code_t c_load(input logic [4:0] rd, input logic [4:0] base,
			input longint imm);
		if (!in12(imm))
			return '0;
		return c_full({imm[11:0], base, 3'd3, rd, OpLoad});
	endfunction

	function automatic code_t c_addi(input logic [4:0] rd, input logic [4:0] rs,
			input longint imm);
		if (ce && rd == rs && rd != 0 && imm != 0 && imm >= -32 && imm < 32)
			return c_short({3'b000, imm[5], rd, imm[4:0], 2'b01});
		return c_itype(rd, rs, imm, OpImm);
	endfunction

	function automatic code_t c_addiw(input logic [4:0] rd, input logic [4:0] rs,
			input longint imm);
		if (ce && rd == rs && rd != 0 && imm >= -32 && imm < 32)
			return c_short({3'b001, imm[5], rd, imm[4:0], 2'b01});
		return c_itype(rd, rs, imm, OpImmW);
	endfunction

	function automatic code_t c_shift(input logic [4:0] rd, input logic [4:0] rs,
			input longint imm);
		if (ce && rd == rs && rd != 0 && imm >= 1 && imm < 64)
			return c_short({3'b000, imm[5], rd, imm[4:0], 2'b10});
		if (rd == 0 || imm < 0 || imm > 63)
			return '0;
		return c_full({6'd0, imm[5:0], rs, 3'd1, rd, OpImm});
	endfunction

	function automatic code_t c_jalr(input logic [4:0] rd, input logic [4:0] rs,
			input longint imm);
		if (ce && imm == 0 && rs != 0 && (rd == 0 || rd == RegRa))
			return c_short({(rd == 0) ? 4'h8 : 4'h9, rs, 5'd0, 2'b10});
		if (!in12(imm))
			return '0;
		return c_full({imm[11:0], rs, 3'b000, rd, OpJalr});
	endfunction

	// push the beats one request should produce
	task automatic encode_request(input req_t r);
		code_t       seq[MaxSeq];
		int          n;
		bit          ok;
		longint      imm, hi, mid, lo, up4, lo12;
		logic [31:0] u;
		logic [63:0] d, h;
		rsp_t        b;
		ok = 1;
		n = 0;
		imm = longint'(r.immediate);
		u = r.immediate;
		for (int k = 0; k < MaxSeq; k++)
			seq[k] = '0;
		if (r.absolute_jump) begin
			if (r.to_addr[63:48] != 0) begin
				ok = 0;
			end else begin
				hi = longint'(r.to_addr[47:28]);
				mid = longint'(r.to_addr[27:16]);
				lo = longint'(r.to_addr[15:0]);
				if (mid >= 2048) begin
					hi = hi + 1;
					mid = mid - 4096;
				end
				seq[n] = c_upper(r.src_reg, hi, OpLui); n++;
				if (mid != 0) begin
					seq[n] = c_addiw(r.src_reg, r.src_reg, mid); n++;
				end
				if (lo == 0) begin
					seq[n] = c_shift(r.src_reg, r.src_reg, 16); n++;
					seq[n] = c_jalr(r.dest_reg, r.src_reg, 0); n++;
				end else begin
					up4 = lo >>> 12;
					lo12 = lo & 64'hfff;
					seq[n] = c_shift(r.src_reg, r.src_reg, 4); n++;
					if (lo12 >= 2048) begin
						up4 = up4 + 1;
						lo12 = lo12 - 4096;
					end
					if (up4 != 0) begin
						seq[n] = c_addi(r.src_reg, r.src_reg, up4); n++;
					end
					seq[n] = c_shift(r.src_reg, r.src_reg, 12); n++;
					seq[n] = c_jalr(r.dest_reg, r.src_reg, lo12); n++;
				end
			end
		end else begin
			n = 1;
			case (r.mode)
				MODE_ADDI:  seq[0] = c_addi(r.dest_reg, r.src_reg, imm);
				MODE_ADDIW: seq[0] = c_addiw(r.dest_reg, r.src_reg, imm);
				MODE_SLLI:  seq[0] = c_shift(r.dest_reg, r.src_reg, imm);
				MODE_LI: begin
					if (ce && imm >= -32 && imm < 32)
						seq[0] = c_short({3'b010, u[5], r.dest_reg, u[4:0], 2'b01});
					else
						seq[0] = c_itype(r.dest_reg, 5'd0, imm, OpImm);
				end
				MODE_ADDSP: begin
					if (ce && imm != 0 && u[3:0] == 0 && imm >= -512 && imm < 512)
						seq[0] = c_short({3'b011, u[9], RegSp, u[4], u[6], u[8:7], u[5],
							2'b01});
					else
						seq[0] = c_itype(RegSp, RegSp, imm, OpImm);
				end
				MODE_SDSP: begin
					if (ce && imm >= 0 && imm < 512 && u[2:0] == 0)
						seq[0] = c_short({3'b111, u[5:3], u[8:6], r.src_reg, 2'b10});
					else
						seq[0] = c_store(r.src_reg, RegSp, imm);
				end
				MODE_LDSP: begin
					if (ce && r.dest_reg != 0 && imm >= 0 && imm < 512 && u[2:0] == 0)
						seq[0] = c_short({3'b011, u[5], r.dest_reg, u[4:3], u[8:6], 2'b10});
					else
						seq[0] = c_load(r.dest_reg, RegSp, imm);
				end
				MODE_JALR:  seq[0] = c_jalr(r.dest_reg, r.src_reg, imm);
				MODE_LUI:   seq[0] = c_upper(r.dest_reg, imm, OpLui);
				MODE_AUIPC: seq[0] = c_upper(r.dest_reg, imm, OpAuipc);
				MODE_JAL: begin
					if (imm >= -1048576 && imm < 1048576)
						seq[0] = c_full({u[20], u[10:1], u[11], u[19:12], r.dest_reg, OpJal});
				end
				MODE_SD:    seq[0] = c_store(r.src_reg, r.temp_reg, imm);
				MODE_LD:    seq[0] = c_load(r.dest_reg, r.src_reg, imm);
				MODE_NOP:   seq[0] = ce ? c_short(16'h0001) : c_full({25'd0, OpImm});
				MODE_STORESYM, MODE_LOADSYM, MODE_JUMP2GB: begin
					d = r.to_addr - r.from_addr;
					if (d == 0 || ((d + 64'h8000_0800) >> 32) != 0) begin
						ok = 0;
					end else begin
						h = ((d + 64'h800) >> 12) & 64'hfffff;
						hi = h[19] ? longint'(h) - 64'sh100000 : longint'(h);
						lo = d[11] ? longint'(d[11:0]) - 4096 : longint'(d[11:0]);
						n = 2;
						if (r.mode == MODE_STORESYM) begin
							seq[0] = c_upper(r.temp_reg, hi, OpAuipc);
							seq[1] = c_store(r.src_reg, r.temp_reg, lo);
						end else if (r.mode == MODE_LOADSYM) begin
							seq[0] = c_upper(r.dest_reg, hi, OpAuipc);
							seq[1] = c_load(r.dest_reg, r.dest_reg, lo);
						end else begin
							seq[0] = c_upper(r.src_reg, hi, OpAuipc);
							seq[1] = c_jalr(r.dest_reg, r.src_reg, lo);
						end
					end
				end
				default: ok = 0;
			endcase
		end
		for (int k = 0; k < n; k++)
			if (seq[k].n == 0)
				ok = 0;
		if (!ok || n == 0) begin
			b.instr_word = '0;
			b.length = 3'd0;
			b.last = 1'b1;
			expected_beats.push_back(b);
		end else begin
			for (int k = 0; k < n; k++) begin
				b.instr_word = seq[k].w;
				b.length = seq[k].n;
				b.last = (k == n - 1);
				expected_beats.push_back(b);
			end
		end
	endtask

	task automatic check_beat(input rsp_t got);
		rsp_t want;
		if (expected_beats.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected beat: word %h len %0d last %0d", got.instr_word,
					got.length, got.last);
			return;
		end
		want = expected_beats.pop_front();
		if (got.instr_word !== want.instr_word || got.length !== want.length ||
				got.last !== want.last) begin
			errors++;
			if (errors <= 10)
				$display("beat mismatch: expected word %h len %0d last %0d, got %h %0d %0d",
					want.instr_word, want.length, want.last,
					got.instr_word, got.length, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ce = 1'b1;
			expected_beats.delete();
			errors = 0;
			beats_seen = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == AddrCfgEnable)
				ce = pwdata[0];
			if (req_valid && req_ready)
				encode_request(req);
			if (rsp_valid && rsp_ready) begin
				beats_seen++;
				check_beat(rsp);
			end
			pending = expected_beats.size();
		end
	end

endmodule

### tb/sv/tb_riscv_instruction_sequence_encoder_unit.sv
// Top of the encoder testbench: clock, reset, request and config stimulus, verdict.
// Depends on rise_pkg, the encoder unit and rise_encode_checker.
module tb_riscv_instruction_sequence_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rise_pkg::*;

	// modes past the defined set must fail with a single zero-length beat
	localparam logic [4:0] ModeFirstUnused = 5'd17;
	localparam logic [4:0] ModeLastUnused  = 5'd31;
	localparam int unsigned CycleLimit = 600000;
	localparam int RandPerPhase = 85;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        psel, penable, pwrite, pready;
	logic [1:0]  paddr;
	logic [31:0] pwdata, prdata;
	int          errors, pending, beats_seen;
	int          reqs_sent;
	int unsigned cycles;

	riscv_instruction_sequence_encoder_unit uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rise_encode_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(errors), .pending(pending), .beats_seen(beats_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic req_t make_req(input logic [4:0] mode, input logic [4:0] rd,
			input logic [4:0] rs, input logic [4:0] tr, input logic [31:0] imm,
			input logic [63:0] from, input logic [63:0] to, input logic abs_j);
		req_t r;
		r.mode = mode;
		r.dest_reg = rd;
		r.src_reg = rs;
		r.temp_reg = tr;
		r.immediate = imm;
		r.from_addr = from;
		r.to_addr = to;
		r.absolute_jump = abs_j;
		return r;
	endfunction

	// one request beat; valid rises after an optional gap and holds until taken
	task automatic send_beat(input req_t r);
		int k;
		int gap;
		k = $urandom_range(0, 99);
		gap = (k < 55) ? 0 : (k < 93) ? $urandom_range(1, 3) : $urandom_range(10, 30);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		reqs_sent++;
		@(negedge clk);
	endtask

	// only between phases: drain, allow the pipe to settle, then a setup-then-access write
	task automatic cfg_write(input logic [1:0] addr, input logic [31:0] data);
		req_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_imm();
		case ($urandom_range(0, 5))
			0: return 32'($urandom_range(0, 80)) - 32'd40;
			1: return 32'($urandom_range(0, 4095)) - 32'd2048;
			2: return 32'($urandom_range(0, 1048575)) - 32'd524288;
			3: return $urandom;
			4: return {$urandom_range(0, 1) ? 23'h7fffff : 23'h0, 6'($urandom_range(0, 63)),
				3'b000};
			default: return 32'($urandom_range(0, 70) * 16) - 32'd560;
		endcase
	endfunction

	// pc-relative distance: near, around both reach limits, zero, or random
	function automatic logic [63:0] rand_delta();
		longint d;
		case ($urandom_range(0, 5))
			0: d = longint'($urandom_range(0, 8192)) - 4096;
			1: d = 64'sh7fff_f7ff - longint'($urandom_range(0, 4)) + 2;
			2: d = -64'sh8000_0800 + longint'($urandom_range(0, 4)) - 2;
			3: d = longint'(int'($urandom));
			4: d = 0;
			default: d = {$urandom, $urandom};
		endcase
		return d;
	endfunction

	function automatic req_t rand_req();
		req_t        r;
		int          k;
		logic [47:0] t48;
		k = $urandom_range(0, 99);
		r.src_reg = $urandom_range(0, 31);
		r.dest_reg = $urandom_range(0, 1) ? r.src_reg : 5'($urandom_range(0, 31));
		r.temp_reg = $urandom_range(0, 31);
		r.immediate = rand_imm();
		r.from_addr = {$urandom, $urandom};
		r.absolute_jump = (k < 10);
		if (k < 10)
			r.mode = $urandom_range(0, 31);
		else if (k < 15)
			r.mode = $urandom_range(ModeFirstUnused, ModeLastUnused);
		else
			r.mode = $urandom_range(MODE_ADDI, MODE_JUMP2GB);
		if (r.absolute_jump) begin
			t48 = {$urandom, 16'($urandom)};
			if ($urandom_range(0, 4) == 0)
				t48[15:0] = '0;
			if ($urandom_range(0, 4) == 0)
				t48[27:16] = '0;
			r.to_addr = {($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'h0, t48};
		end else begin
			r.to_addr = r.from_addr + rand_delta();
		end
		return r;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			send_beat(rand_req());
	endtask

	// result side: long ready stretches, short stalls, the odd long stall
	initial begin
		int k;
		rsp_ready = 1'b0;
		forever begin
			k = $urandom_range(0, 99);
			if (k < 60) begin
				rsp_ready = 1'b1;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end else if (k < 95) begin
				rsp_ready = 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end else begin
				rsp_ready = 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end
		end
	end

	initial begin
		reqs_sent = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		cfg_write(AddrCfgEnable, 32'd1);
		// directed: operand extremes, each mode, the compressed-form corner cases
		send_beat(make_req(MODE_ADDI, 5'd9, 5'd9, 5'd0, -32'sd32, '0, '0, 1'b0));
		send_beat(make_req(MODE_ADDI, 5'd31, 5'd31, 5'd0, 32'd0, '0, '0, 1'b0));
		send_beat(make_req(MODE_ADDIW, 5'd5, 5'd5, 5'd0, 32'd0, '0, '0, 1'b0));
		send_beat(make_req(MODE_SLLI, 5'd7, 5'd7, 5'd0, 32'd63, '0, '0, 1'b0));
		send_beat(make_req(MODE_SLLI, 5'd7, 5'd8, 5'd0, 32'd64, '0, '0, 1'b0));
		send_beat(make_req(MODE_LI, 5'd0, 5'd0, 5'd0, 32'd2047, '0, '0, 1'b0));
		send_beat(make_req(MODE_LI, 5'd3, 5'd0, 5'd0, 32'd31, '0, '0, 1'b0));
		send_beat(make_req(MODE_ADDSP, 5'd0, 5'd0, 5'd0, -32'sd512, '0, '0, 1'b0));
		send_beat(make_req(MODE_ADDSP, 5'd0, 5'd0, 5'd0, 32'd496, '0, '0, 1'b0));
		send_beat(make_req(MODE_SDSP, 5'd0, 5'd31, 5'd0, 32'd504, '0, '0, 1'b0));
		send_beat(make_req(MODE_LDSP, 5'd0, 5'd0, 5'd0, 32'd8, '0, '0, 1'b0));
		send_beat(make_req(MODE_JALR, 5'd0, 5'd0, 5'd0, 32'd0, '0, '0, 1'b0));
		send_beat(make_req(MODE_JALR, 5'd1, 5'd12, 5'd0, 32'd0, '0, '0, 1'b0));
		send_beat(make_req(MODE_LUI, 5'd4, 5'd0, 5'd0, 32'h7ffff, '0, '0, 1'b0));
		send_beat(make_req(MODE_AUIPC, 5'd4, 5'd0, 5'd0, 32'hfff80000, '0, '0, 1'b0));
		send_beat(make_req(MODE_JAL, 5'd1, 5'd0, 5'd0, 32'hfff00000, '0, '0, 1'b0));
		send_beat(make_req(MODE_JAL, 5'd1, 5'd0, 5'd0, 32'h00100000, '0, '0, 1'b0));
		send_beat(make_req(MODE_SD, 5'd0, 5'd17, 5'd30, -32'sd2048, '0, '0, 1'b0));
		send_beat(make_req(MODE_LD, 5'd6, 5'd2, 5'd0, 32'd2047, '0, '0, 1'b0));
		send_beat(make_req(MODE_NOP, 5'd0, 5'd0, 5'd0, 32'd0, '0, '0, 1'b0));
		// zero distance fails; far edge of reach passes, just past it fails; unused mode fails
		send_beat(make_req(MODE_STORESYM, 5'd0, 5'd10, 5'd5, 32'd0, 64'h1000, 64'h1000, 1'b0));
		send_beat(make_req(MODE_LOADSYM, 5'd11, 5'd0, 5'd0, 32'd0, 64'h0,
			64'h7fff_f7ff, 1'b0));
		send_beat(make_req(MODE_JUMP2GB, 5'd1, 5'd6, 5'd0, 32'd0, '1, 64'h8000_07ff, 1'b0));
		send_beat(make_req(ModeLastUnused, 5'd1, 5'd1, 5'd1, 32'd0, '0, '0, 1'b0));
		// absolute jumps: low half zero, and a target above 48 bits
		send_beat(make_req(ModeFirstUnused, 5'd1, 5'd6, 5'd0, '0, '0,
			64'h0000_7fff_fff8_0000, 1'b1));
		send_beat(make_req(MODE_NOP, 5'd0, 5'd6, 5'd0, '0, '0, 64'h0001_0000_0000_8800, 1'b1));

		run_random(RandPerPhase);
		cfg_write(AddrCfgEnable, 32'd0);
		send_beat(make_req(MODE_NOP, 5'd0, 5'd0, 5'd0, 32'd0, '0, '0, 1'b0));
		run_random(RandPerPhase);
		cfg_write(AddrCfgEnable, 32'hffff_ffff);
		run_random(RandPerPhase);
		req_valid = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d requests sent, %0d result beats checked across compressed", reqs_sent,
			beats_seen);
		$display("and full-only settings; %0d mismatches", errors);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
